@@ design/vdfs_pkg.sv @@
`default_nettype none
package vdfs_pkg;

  localparam int unsigned PosW  = 20;
  localparam int unsigned ExtW  = 19;
  localparam int unsigned InvW  = 24;
  localparam int unsigned DistW = 32;
  localparam int unsigned GradW = 48;
  localparam int unsigned AccW  = 36;
  localparam int unsigned DiffW = 37;
  localparam int unsigned WtW   = 25;
  localparam int unsigned ProdW = 62;
  localparam int unsigned CW    = 44;
  localparam int unsigned FrW   = 16;

  localparam logic signed [DistW-1:0] FarDist = 32'sd40960000;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_REL   = 10'b0000000100,
    S_SEL   = 10'b0000001000,
    S_MUL   = 10'b0000010000,
    S_ACC   = 10'b0000100000,
    S_WR    = 10'b0001000000,
    S_ADDR  = 10'b0010000000,
    S_FETCH = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_e;

  typedef logic [4:0] op_t;
  localparam op_t OP_CX   = 5'd0;
  localparam op_t OP_CY   = 5'd1;
  localparam op_t OP_CZ   = 5'd2;
  localparam op_t OP_LX   = 5'd3;
  localparam op_t OP_LY   = 5'd4;
  localparam op_t OP_LZ   = 5'd5;
  localparam op_t OP_V00  = 5'd6;
  localparam op_t OP_V01  = 5'd7;
  localparam op_t OP_V10  = 5'd8;
  localparam op_t OP_V11  = 5'd9;
  localparam op_t OP_V0   = 5'd10;
  localparam op_t OP_V1   = 5'd11;
  localparam op_t OP_DIST = 5'd12;
  localparam op_t OP_E0   = 5'd13;
  localparam op_t OP_E1   = 5'd14;
  localparam op_t OP_GXP  = 5'd15;
  localparam op_t OP_GYP  = 5'd16;
  localparam op_t OP_GX   = 5'd17;
  localparam op_t OP_GY   = 5'd18;
  localparam op_t OP_GZ   = 5'd19;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_ORIGIN_X = 3'd0;
  localparam reg_idx_t REG_ORIGIN_Y = 3'd1;
  localparam reg_idx_t REG_ORIGIN_Z = 3'd2;
  localparam reg_idx_t REG_EXTENT_X = 3'd3;
  localparam reg_idx_t REG_EXTENT_Y = 3'd4;
  localparam reg_idx_t REG_EXTENT_Z = 3'd5;
  localparam reg_idx_t REG_INV_RES  = 3'd6;

endpackage
`default_nettype wire

@@ design/voxel_distance_field_sampler.sv @@
`default_nettype none
// channel    | direction | handshake                        | payload
// config     | in / out  | psel, penable, pwrite, pready    | paddr, pwdata, prdata
// item       | in        | start high while busy low        | func_i, pos_*_i, sample_distance_i
// result     | out       | valid_o, one cycle               | distance_o, grad_*_o
//
// after reset a clearing pass marks every voxel unknown; busy is high
// an in-map query makes twenty passes through the one shared multiplier,
// plus eight reads of the voxel memory's read port
// busy stays high until the item is finished; the receiver cannot stall results
module voxel_distance_field_sampler import vdfs_pkg::*; #(
  parameter int unsigned DIM_X = 64,
  parameter int unsigned DIM_Y = 64,
  parameter int unsigned DIM_Z = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [4:0]               paddr,
  input  wire logic [31:0]              pwdata,
  output logic      [31:0]              prdata,
  output logic                          pready,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic                     func_i,
  input  wire logic signed [PosW-1:0]   pos_x_i,
  input  wire logic signed [PosW-1:0]   pos_y_i,
  input  wire logic signed [PosW-1:0]   pos_z_i,
  input  wire logic signed [DistW-1:0]  sample_distance_i,
  output logic                          valid_o,
  output logic signed [DistW-1:0]       distance_o,
  output logic signed [GradW-1:0]       grad_x_o,
  output logic signed [GradW-1:0]       grad_y_o,
  output logic signed [GradW-1:0]       grad_z_o
);

  localparam int unsigned NVOX = DIM_X * DIM_Y * DIM_Z;
  localparam int unsigned AW   = $clog2(NVOX);
  localparam int unsigned DMAX = (DIM_X > DIM_Y) ? ((DIM_X > DIM_Z) ? DIM_X : DIM_Z)
                                                 : ((DIM_Y > DIM_Z) ? DIM_Y : DIM_Z);
  localparam int unsigned IW   = $clog2(DMAX);
  localparam int unsigned DIMS [3] = '{DIM_X, DIM_Y, DIM_Z};

  // configuration
  logic signed [PosW-1:0] origin_q [3];
  logic [ExtW-1:0]        extent_q [3];
  logic [InvW-1:0]        inv_q;
  logic                   wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q[0] <= -20'sd40960;
      origin_q[1] <= -20'sd40960;
      origin_q[2] <= -20'sd4096;
      extent_q[0] <= 19'd81920;
      extent_q[1] <= 19'd81920;
      extent_q[2] <= 19'd16384;
      inv_q       <= 24'd436907;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_ORIGIN_X: origin_q[0] <= pwdata[PosW-1:0];
        REG_ORIGIN_Y: origin_q[1] <= pwdata[PosW-1:0];
        REG_ORIGIN_Z: origin_q[2] <= pwdata[PosW-1:0];
        REG_EXTENT_X: extent_q[0] <= pwdata[ExtW-1:0];
        REG_EXTENT_Y: extent_q[1] <= pwdata[ExtW-1:0];
        REG_EXTENT_Z: extent_q[2] <= pwdata[ExtW-1:0];
        REG_INV_RES:  inv_q       <= pwdata[InvW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_ORIGIN_X: prdata = 32'(origin_q[0]);
      REG_ORIGIN_Y: prdata = 32'(origin_q[1]);
      REG_ORIGIN_Z: prdata = 32'(origin_q[2]);
      REG_EXTENT_X: prdata = {13'd0, extent_q[0]};
      REG_EXTENT_Y: prdata = {13'd0, extent_q[1]};
      REG_EXTENT_Z: prdata = {13'd0, extent_q[2]};
      REG_INV_RES:  prdata = {8'd0, inv_q};
      default:      prdata = 32'd0;
    endcase
  end

  // control
  state_e          state_q, state_d;
  op_t             op_q, op_d;
  logic [3:0]      fc_q, fc_d;
  logic [AW-1:0]   clr_q, clr_d;

  // item and datapath
  logic                    func_q;
  logic signed [PosW-1:0]  pos_q [3];
  logic signed [DistW-1:0] sample_q;
  logic [ExtW-1:0]         rel_q [3];
  logic [CW-1:0]           c_q [3];
  logic [CW-1:0]           lim_q [3];
  logic [FrW-1:0]          fr_q [3];
  logic [IW-1:0]           idx_q [3][2];
  logic                    ok_q [3][2];
  logic                    okp_q;
  logic signed [DistW-1:0] v_q [8];
  logic signed [AccW-1:0]  v00_q, v01_q, v10_q, v11_q, v0_q, v1_q, e0_q, e1_q, gxp_q, gyp_q;
  logic signed [AccW-1:0]  a_q;
  logic signed [DiffW-1:0] diff_q;
  logic signed [WtW-1:0]   w_q;
  logic signed [ProdW-1:0] p_q;
  logic signed [DistW-1:0] dist_q;
  logic signed [GradW-1:0] gx_q, gy_q, gz_q;

  // voxel memory, top bit is the known flag
  logic [DistW:0]  mem_q [NVOX];
  logic [DistW:0]  rd_q;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [DistW:0]  mem_wdata;
  logic [AW-1:0]   raddr;

  function automatic logic [AW-1:0] vox_addr(logic [IW-1:0] ix, logic [IW-1:0] iy,
                                             logic [IW-1:0] iz);
    return (AW'(ix) * AW'(DIM_Y) + AW'(iy)) * AW'(DIM_Z) + AW'(iz);
  endfunction

  // neighbour index inside the store and its centre inside the extent
  function automatic logic axis_ok(logic [16:0] i, logic [16:0] dim, logic [CW-1:0] lim);
    logic [CW:0] centre;
    centre = {i, 1'b1, 27'd0};
    return (i < dim) && (centre < {1'b0, lim});
  endfunction

  // range test
  logic signed [PosW:0] rel [3];
  logic                 inmap;
  always_comb begin
    inmap = 1'b1;
    for (int n = 0; n < 3; n++) begin
      rel[n] = {pos_q[n][PosW-1], pos_q[n]} - {origin_q[n][PosW-1], origin_q[n]};
      if (rel[n][PosW] || (rel[n][PosW-1:0] >= {1'b0, extent_q[n]})) inmap = 1'b0;
    end
  end

  // store address
  logic [15:0]   st_i [3];
  logic          st_ok;
  logic [AW-1:0] st_addr;
  always_comb begin
    st_ok = 1'b1;
    for (int n = 0; n < 3; n++) begin
      st_i[n] = c_q[n][CW-1:28];
      if (st_i[n] >= 16'(DIMS[n])) st_ok = 1'b0;
    end
    st_addr = vox_addr(IW'(st_i[0]), IW'(st_i[1]), IW'(st_i[2]));
  end

  // neighbour fetch
  logic [2:0] nb;
  logic       nb_ok;
  assign nb    = fc_q[2:0];
  assign nb_ok = ok_q[0][nb[2]] && ok_q[1][nb[1]] && ok_q[2][nb[0]];
  assign raddr = vox_addr(idx_q[0][nb[2]], idx_q[1][nb[1]], idx_q[2][nb[0]]);

  assign mem_we    = (state_q == S_CLEAR) || ((state_q == S_WR) && st_ok);
  assign mem_waddr = (state_q == S_CLEAR) ? clr_q : st_addr;
  assign mem_wdata = (state_q == S_CLEAR) ? '0 : {1'b1, sample_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[raddr];
  end

  // operand selection for the shared multiplier
  logic signed [AccW-1:0] d00, d01, d10, d11, op_a, op_b;
  logic signed [WtW-1:0]  op_w;
  logic signed [WtW-1:0]  w_inv;
  assign d00   = AccW'(v_q[4]) - AccW'(v_q[0]);
  assign d01   = AccW'(v_q[5]) - AccW'(v_q[1]);
  assign d10   = AccW'(v_q[6]) - AccW'(v_q[2]);
  assign d11   = AccW'(v_q[7]) - AccW'(v_q[3]);
  assign w_inv = {1'b0, inv_q};

  always_comb begin
    op_a = '0;
    op_b = '0;
    op_w = '0;
    case (op_q)
      OP_CX:   begin op_b = {17'd0, rel_q[0]}; op_w = w_inv; end
      OP_CY:   begin op_b = {17'd0, rel_q[1]}; op_w = w_inv; end
      OP_CZ:   begin op_b = {17'd0, rel_q[2]}; op_w = w_inv; end
      OP_LX:   begin op_b = {17'd0, extent_q[0]}; op_w = w_inv; end
      OP_LY:   begin op_b = {17'd0, extent_q[1]}; op_w = w_inv; end
      OP_LZ:   begin op_b = {17'd0, extent_q[2]}; op_w = w_inv; end
      OP_V00:  begin op_a = AccW'(v_q[0]); op_b = AccW'(v_q[4]); op_w = {9'd0, fr_q[0]}; end
      OP_V01:  begin op_a = AccW'(v_q[1]); op_b = AccW'(v_q[5]); op_w = {9'd0, fr_q[0]}; end
      OP_V10:  begin op_a = AccW'(v_q[2]); op_b = AccW'(v_q[6]); op_w = {9'd0, fr_q[0]}; end
      OP_V11:  begin op_a = AccW'(v_q[3]); op_b = AccW'(v_q[7]); op_w = {9'd0, fr_q[0]}; end
      OP_V0:   begin op_a = v00_q; op_b = v10_q; op_w = {9'd0, fr_q[1]}; end
      OP_V1:   begin op_a = v01_q; op_b = v11_q; op_w = {9'd0, fr_q[1]}; end
      OP_DIST: begin op_a = v0_q; op_b = v1_q; op_w = {9'd0, fr_q[2]}; end
      OP_E0:   begin op_a = d00; op_b = d10; op_w = {9'd0, fr_q[1]}; end
      OP_E1:   begin op_a = d01; op_b = d11; op_w = {9'd0, fr_q[1]}; end
      OP_GXP:  begin op_a = e0_q; op_b = e1_q; op_w = {9'd0, fr_q[2]}; end
      OP_GYP:  begin
        op_a = v10_q - v00_q;
        op_b = v11_q - v01_q;
        op_w = {9'd0, fr_q[2]};
      end
      OP_GX:   begin op_b = gxp_q; op_w = w_inv; end
      OP_GY:   begin op_b = gyp_q; op_w = w_inv; end
      OP_GZ:   begin op_b = v1_q - v0_q; op_w = w_inv; end
      default: ;
    endcase
  end

  // rounding of the product
  logic signed [ProdW-1:0] p16, p12;
  logic signed [AccW-1:0]  lerp_res;
  logic signed [DistW-1:0] dist_sat;
  logic signed [GradW-1:0] grad_sat;
  assign p16      = (p_q + 62'sd32768) >>> 16;
  assign p12      = (p_q + 62'sd2048) >>> 12;
  assign lerp_res = a_q + p16[AccW-1:0];

  always_comb begin
    if ((&lerp_res[AccW-1:DistW-1]) || !(|lerp_res[AccW-1:DistW-1])) begin
      dist_sat = lerp_res[DistW-1:0];
    end else begin
      dist_sat = lerp_res[AccW-1] ? {1'b1, {(DistW-1){1'b0}}} : {1'b0, {(DistW-1){1'b1}}};
    end
    if ((&p12[ProdW-1:GradW-1]) || !(|p12[ProdW-1:GradW-1])) begin
      grad_sat = p12[GradW-1:0];
    end else begin
      grad_sat = p12[ProdW-1] ? {1'b1, {(GradW-1){1'b0}}} : {1'b0, {(GradW-1){1'b1}}};
    end
  end

  // neighbour bases and fractions
  logic [CW:0]   t_ax [3];
  logic [16:0]   hi_ax [3];
  always_comb begin
    for (int n = 0; n < 3; n++) begin
      t_ax[n]  = {1'b0, c_q[n]} + 45'(2 ** 27);
      hi_ax[n] = {1'b0, t_ax[n][CW-1:28]};
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          func_q   <= func_i;
          pos_q[0] <= pos_x_i;
          pos_q[1] <= pos_y_i;
          pos_q[2] <= pos_z_i;
          sample_q <= sample_distance_i;
        end
      end
      S_REL: begin
        for (int n = 0; n < 3; n++) rel_q[n] <= rel[n][ExtW-1:0];
        dist_q <= FarDist;
        gx_q   <= '0;
        gy_q   <= '0;
        gz_q   <= '0;
      end
      S_SEL: begin
        a_q    <= op_a;
        diff_q <= DiffW'(op_b) - DiffW'(op_a);
        w_q    <= op_w;
      end
      S_MUL: begin
        p_q <= diff_q * w_q;
      end
      S_ACC: begin
        case (op_q)
          OP_CX:   c_q[0]   <= p_q[CW-1:0];
          OP_CY:   c_q[1]   <= p_q[CW-1:0];
          OP_CZ:   c_q[2]   <= p_q[CW-1:0];
          OP_LX:   lim_q[0] <= p_q[CW-1:0];
          OP_LY:   lim_q[1] <= p_q[CW-1:0];
          OP_LZ:   lim_q[2] <= p_q[CW-1:0];
          OP_V00:  v00_q    <= lerp_res;
          OP_V01:  v01_q    <= lerp_res;
          OP_V10:  v10_q    <= lerp_res;
          OP_V11:  v11_q    <= lerp_res;
          OP_V0:   v0_q     <= lerp_res;
          OP_V1:   v1_q     <= lerp_res;
          OP_DIST: dist_q   <= dist_sat;
          OP_E0:   e0_q     <= lerp_res;
          OP_E1:   e1_q     <= lerp_res;
          OP_GXP:  gxp_q    <= lerp_res;
          OP_GYP:  gyp_q    <= lerp_res;
          OP_GX:   gx_q     <= grad_sat;
          OP_GY:   gy_q     <= grad_sat;
          OP_GZ:   gz_q     <= grad_sat;
          default: ;
        endcase
      end
      S_ADDR: begin
        for (int n = 0; n < 3; n++) begin
          fr_q[n]     <= t_ax[n][27:12];
          idx_q[n][1] <= IW'(hi_ax[n]);
          idx_q[n][0] <= IW'(hi_ax[n] - 17'd1);
          ok_q[n][1]  <= axis_ok(hi_ax[n], 17'(DIMS[n]), lim_q[n]);
          ok_q[n][0]  <= (hi_ax[n] != 17'd0) &&
                         axis_ok(hi_ax[n] - 17'd1, 17'(DIMS[n]), lim_q[n]);
        end
      end
      S_FETCH: begin
        okp_q <= nb_ok;
        // read data is registered and belongs to the address of the previous cycle
        if (fc_q != 4'd0) begin
          v_q[nb - 3'd1] <= (okp_q && rd_q[DistW]) ? rd_q[DistW-1:0] : FarDist;
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    fc_d    = fc_q;
    clr_d   = clr_q;
    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(NVOX - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_d = S_REL;
      end
      S_REL: begin
        op_d = OP_CX;
        if (inmap) state_d = S_SEL;
        else state_d = func_q ? S_DONE : S_IDLE;
      end
      S_SEL: state_d = S_MUL;
      S_MUL: state_d = S_ACC;
      S_ACC: begin
        op_d = op_q + 5'd1;
        if (op_q == OP_LZ) begin
          state_d = func_q ? S_ADDR : S_WR;
        end else if (op_q == OP_GZ) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SEL;
        end
      end
      S_WR: state_d = S_IDLE;
      S_ADDR: begin
        fc_d    = 4'd0;
        state_d = S_FETCH;
      end
      S_FETCH: begin
        fc_d = fc_q + 4'd1;
        if (fc_q == 4'd8) begin
          op_d    = OP_V00;
          state_d = S_SEL;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      op_q    <= OP_CX;
      fc_q    <= 4'd0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      fc_q    <= fc_d;
      clr_q   <= clr_d;
    end
  end

  assign busy       = (state_q != S_IDLE);
  assign valid_o    = (state_q == S_DONE);
  assign distance_o = dist_q;
  assign grad_x_o   = gx_q;
  assign grad_y_o   = gy_q;
  assign grad_z_o   = gz_q;

`ifndef SYNTH
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result strobe longer than one cycle");

  a_mem_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_CLEAR || state_q == S_WR))
    else $error("voxel write outside clear or store");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == S_REL)) else $error("accepted item not started");

  a_fetch_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FETCH) |-> (op_q == OP_V00 || fc_q == 4'd0))
    else $error("fetch entered with wrong op");

  a_result_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> func_q) else $error("result from a store item");
`endif

endmodule
`default_nettype wire
